/* hdl/tsc_pkg.sv */
// shared types, codes and sizes for the typed statistics counter bank
// no dependencies; used by the top level and the testbench
`default_nettype none

package tsc_pkg;

    localparam int IDX_W     = 6;
    localparam int OP_W      = 3;
    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 64;
    localparam int COUNT_W   = 32;

    localparam int NUM_COUNTERS_DEF = 64;

    // operation codes carried in the input tuser
    localparam logic [OP_W-1:0] OP_INCR   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SET    = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CONFIG = 3'd4;

    // counter kinds
    localparam logic [KIND_W-1:0] KIND_NORMAL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AVERAGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MAXIMUM  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FUNCTION = 2'd3;

    // one stored counter
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
    } t_entry;

endpackage

`default_nettype wire

/* hdl/typed_statistics_counter_bank_top.sv */
// top level of the typed statistics counter bank: stream in, stream out
// depends on tsc_pkg and tsc_ram
// result path: stage 1 with the ram read, then the result register; a forwarding register
// serves back-to-back items on one counter; one item per cycle while the output does not stall
// reset: synchronous active-low; clears control and all entry-valid bits, so every
// counter reads as zero value, zero count, normal kind; no clearing pass
`default_nettype none

module typed_statistics_counter_bank_top #(
    parameter int NUM_COUNTERS = tsc_pkg::NUM_COUNTERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // counter_index[5:0], operand[69:6], new_kind[71:70]
    input  wire logic [2:0]  s_axis_tuser,  // op[2:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // counter_value[63:0], update_count[95:64]
    output logic [1:0]       m_axis_tuser   // counter_kind[1:0]
);

    // only indices reachable through the 6-bit field need storage
    localparam int IDX_SPAN = 2 ** tsc_pkg::IDX_W;
    localparam int DEPTH    = (NUM_COUNTERS < IDX_SPAN) ? NUM_COUNTERS : IDX_SPAN;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW       = $bits(tsc_pkg::t_entry);

    // input field unpack
    logic [tsc_pkg::IDX_W-1:0]   w_in_idx;
    logic [tsc_pkg::VALUE_W-1:0] w_in_operand;
    logic [tsc_pkg::KIND_W-1:0]  w_in_kind;
    logic [AW-1:0]               w_in_addr;
    logic                        w_in_range;
    logic                        w_in_acc;

    assign w_in_idx     = s_axis_tdata[5:0];
    assign w_in_operand = s_axis_tdata[69:6];
    assign w_in_kind    = s_axis_tdata[71:70];
    assign w_in_addr    = AW'(w_in_idx);
    assign w_in_range   = 32'(w_in_idx) < 32'(NUM_COUNTERS);

    // stage 1: item waiting for its ram read data
    logic                        r_s1_valid;
    logic [tsc_pkg::OP_W-1:0]    r_s1_op;
    logic [AW-1:0]               r_s1_addr;
    logic                        r_s1_in_range;
    logic [tsc_pkg::VALUE_W-1:0] r_s1_operand;
    logic [tsc_pkg::KIND_W-1:0]  r_s1_new_kind;
    logic                        r_s1_hit;      // entry had been written before the read
    logic                        r_s1_fwd;      // use the forwarding register instead of ram
    tsc_pkg::t_entry             r_fwd_entry;

    // per-entry written flags, cleared at reset
    logic [DEPTH-1:0]            r_valid;

    // result register
    logic                        r_out_valid;
    tsc_pkg::t_entry             r_out_entry;

    logic                        w_adv;
    logic                        w_we;
    logic [EW-1:0]               w_ram_q;
    tsc_pkg::t_entry             w_old;
    tsc_pkg::t_entry             w_new;
    tsc_pkg::t_entry             w_result;
    logic [tsc_pkg::VALUE_W-1:0] w_sum;

    // stage 1 moves on when the result register is free or being drained
    assign w_adv         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    tsc_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_addr),
        .i_wdata (w_new),
        .i_re    (w_in_acc),
        .i_raddr (w_in_addr),
        .o_rdata (w_ram_q)
    );

    // current contents: forwarded write, stored entry, or reset value
    always_comb begin
        if (r_s1_fwd) begin
            w_old = r_fwd_entry;
        end else if (r_s1_hit) begin
            w_old = tsc_pkg::t_entry'(w_ram_q);
        end else begin
            w_old = '0;
        end
    end

    // incr is add with an operand of one
    assign w_sum = w_old.value + ((r_s1_op == tsc_pkg::OP_INCR) ?
                   tsc_pkg::VALUE_W'(1) : r_s1_operand);

    // read-modify-write of one counter
    always_comb begin
        w_new = w_old;
        w_we  = 1'b0;
        unique case (r_s1_op)
            tsc_pkg::OP_INCR, tsc_pkg::OP_ADD: begin
                w_new.value = w_sum;
                w_new.count = w_old.count + tsc_pkg::COUNT_W'(1);
                w_we        = 1'b1;
            end
            tsc_pkg::OP_SET: begin
                // normal replaces, maximum keeps the larger, others keep the value
                if (w_old.kind == tsc_pkg::KIND_NORMAL) begin
                    w_new.value = r_s1_operand;
                end else if (w_old.kind == tsc_pkg::KIND_MAXIMUM &&
                             r_s1_operand > w_old.value) begin
                    w_new.value = r_s1_operand;
                end
                w_new.count = w_old.count + tsc_pkg::COUNT_W'(1);
                w_we        = 1'b1;
            end
            tsc_pkg::OP_CONFIG: begin
                w_new.kind  = r_s1_new_kind;
                w_new.value = '0;
                w_new.count = '0;
                w_we        = 1'b1;
            end
            default: begin
                // read and unused codes leave the counter alone
                w_we = 1'b0;
            end
        endcase
        w_we = w_we && w_adv && r_s1_in_range;
    end

    // out-of-range index returns all zero
    assign w_result = r_s1_in_range ? w_new : '0;

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
                // same counter written at this edge: ram read sees stale data
                r_s1_fwd   <= w_we && w_in_range && (w_in_addr == r_s1_addr);
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
                r_s1_fwd   <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_op       <= s_axis_tuser;
            r_s1_addr     <= w_in_addr;
            r_s1_in_range <= w_in_range;
            r_s1_operand  <= w_in_operand;
            r_s1_new_kind <= w_in_kind;
            r_s1_hit      <= w_in_range && r_valid[w_in_addr];
        end
        if (w_we) begin
            r_fwd_entry <= w_new;
        end
    end

    // entry-written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[r_s1_addr] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_entry <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_entry.count, r_out_entry.value};
    assign m_axis_tuser  = r_out_entry.kind;

endmodule

`default_nettype wire

/* hdl/tsc_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read returns the old contents on a same-cycle write
`default_nettype none

module tsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/tsc_checker.sv */
// port-level checker for the typed statistics counter bank, bound to the top
// depends on the ports of typed_statistics_counter_bank_top only
`default_nettype none

module tsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // items accepted but not yet delivered
    logic [1:0] r_pending;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (!w_in_acc && w_out_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no result without an accepted item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 2'd0)
        else $error("result without a pending item");

    // at most two items in flight
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many items in flight");

    // two items in flight means input must be blocked unless output drains
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd2 && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline full");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind typed_statistics_counter_bank_top tsc_checker u_tsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* test/tb_top.sv */
// testbench for typed_statistics_counter_bank_top: directed and random counter operations
// depends on tsc_pkg and the block's rtl; predicts each result and checks it field by field
`timescale 1ns / 1ps

module tb_top;

    // op codes with no defined operation, the block treats them as read
    localparam logic [tsc_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [tsc_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [tsc_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

    localparam int NUM_CTRS     = tsc_pkg::NUM_COUNTERS_DEF;
    localparam int STALL_PCT    = 14;
    localparam int HANG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 6;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [71:0]   s_axis_tdata;   // counter_index[5:0], operand[69:6], new_kind[71:70]
    logic [2:0]    s_axis_tuser;   // op[2:0]
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [95:0]   m_axis_tdata;   // counter_value[63:0], update_count[95:64]
    logic [1:0]    m_axis_tuser;   // counter_kind[1:0]

    // predicted bank contents
    logic [tsc_pkg::VALUE_W-1:0] bank_values [NUM_CTRS];
    logic [tsc_pkg::COUNT_W-1:0] bank_counts [NUM_CTRS];
    logic [tsc_pkg::KIND_W-1:0]  bank_kinds  [NUM_CTRS];

    // counter snapshots still owed by the block, oldest first
    tsc_pkg::t_entry counter_snapshot_q[$];
    tsc_pkg::t_entry owed_snap;

    int  errors;
    int  idle_cycles;
    bit  src_gap_en;
    bit  sink_stall_en;

    typed_statistics_counter_bank_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // applies one operation to the predicted bank and returns the counter afterward
    function automatic tsc_pkg::t_entry apply_counter_op(
            input logic [tsc_pkg::OP_W-1:0]    op,
            input logic [tsc_pkg::IDX_W-1:0]   idx,
            input logic [tsc_pkg::VALUE_W-1:0] operand,
            input logic [tsc_pkg::KIND_W-1:0]  kind);
        tsc_pkg::t_entry snap;
        case (op)
            tsc_pkg::OP_INCR: begin
                bank_values[idx] = bank_values[idx] + 64'd1;
                bank_counts[idx] = bank_counts[idx] + 32'd1;
            end
            tsc_pkg::OP_ADD: begin
                bank_values[idx] = bank_values[idx] + operand;
                bank_counts[idx] = bank_counts[idx] + 32'd1;
            end
            tsc_pkg::OP_SET: begin
                // maximum keeps the larger, normal overwrites, others keep the value
                if (bank_kinds[idx] == tsc_pkg::KIND_MAXIMUM) begin
                    if (operand > bank_values[idx]) bank_values[idx] = operand;
                end else if (bank_kinds[idx] == tsc_pkg::KIND_NORMAL) begin
                    bank_values[idx] = operand;
                end
                bank_counts[idx] = bank_counts[idx] + 32'd1;
            end
            tsc_pkg::OP_CONFIG: begin
                bank_kinds[idx]  = kind;
                bank_values[idx] = '0;
                bank_counts[idx] = '0;
            end
            default: ; // read and the spare codes change nothing
        endcase
        snap.value = bank_values[idx];
        snap.count = bank_counts[idx];
        snap.kind  = bank_kinds[idx];
        return snap;
    endfunction

    // presents one item at the falling edge and holds it until the block takes it
    task automatic send_item(input logic [tsc_pkg::OP_W-1:0]    op,
                             input logic [tsc_pkg::IDX_W-1:0]   idx,
                             input logic [tsc_pkg::VALUE_W-1:0] operand,
                             input logic [tsc_pkg::KIND_W-1:0]  kind);
        while (src_gap_en && $urandom_range(0, 99) < STALL_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {kind, operand, idx};
        s_axis_tuser  = op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        counter_snapshot_q.push_back(apply_counter_op(op, idx, operand, kind));
        @(negedge i_clk);
    endtask

    // stops sending and waits until every owed result is back
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (counter_snapshot_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // picks an operand, often close to the counter's current value so max compares tie
    function automatic logic [tsc_pkg::VALUE_W-1:0] pick_operand(
            input logic [tsc_pkg::IDX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return {$urandom, $urandom};
        if (r < 60) return 64'($urandom_range(0, 255));
        if (r < 68) return '1;
        if (r < 78) return {32'hffff_ffff, $urandom};
        if (r < 89) return bank_values[idx] + 64'($urandom_range(0, 3));
        return bank_values[idx] - 64'($urandom_range(0, 3));
    endfunction

    function automatic logic [tsc_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return tsc_pkg::OP_INCR;
        if (r < 42) return tsc_pkg::OP_ADD;
        if (r < 68) return tsc_pkg::OP_SET;
        if (r < 78) return tsc_pkg::OP_READ;
        if (r < 91) return tsc_pkg::OP_CONFIG;
        if (r < 94) return OP_SPARE_A;
        if (r < 97) return OP_SPARE_B;
        return OP_SPARE_C;
    endfunction

    // the bank must read as all zero, normal kind after reset
    task automatic test_reset_contents();
        send_item(tsc_pkg::OP_READ, 6'd0, '0, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_READ, 6'd63, '1, tsc_pkg::KIND_FUNCTION);
    endtask

    // increment, add and set on normal counters, including value wrap
    task automatic test_normal_ops();
        send_item(tsc_pkg::OP_INCR, 6'd0, '0, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_ADD, 6'd0, '1, tsc_pkg::KIND_NORMAL);   // 1 + all ones wraps
        send_item(tsc_pkg::OP_ADD, 6'd63, '0, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_SET, 6'd63, '1, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_INCR, 6'd63, '0, tsc_pkg::KIND_NORMAL); // all ones plus one wraps
    endtask

    // maximum counter: smaller, equal and larger set operands
    task automatic test_maximum_kind();
        send_item(tsc_pkg::OP_CONFIG, 6'd1, '0, tsc_pkg::KIND_MAXIMUM);
        send_item(tsc_pkg::OP_SET, 6'd1, 64'd100, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_SET, 6'd1, 64'd50, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_SET, 6'd1, 64'd100, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_SET, 6'd1, '1, tsc_pkg::KIND_NORMAL);
    endtask

    // set leaves average and function counters alone but still counts
    task automatic test_passive_kinds();
        send_item(tsc_pkg::OP_CONFIG, 6'd2, '0, tsc_pkg::KIND_AVERAGE);
        send_item(tsc_pkg::OP_SET, 6'd2, 64'd77, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_ADD, 6'd2, 64'd5, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_CONFIG, 6'd3, '0, tsc_pkg::KIND_FUNCTION);
        send_item(tsc_pkg::OP_SET, 6'd3, 64'd9, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_INCR, 6'd3, '0, tsc_pkg::KIND_NORMAL);
    endtask

    // spare op codes behave as read, then reconfigure clears a used counter
    task automatic test_spare_ops_and_clear();
        send_item(OP_SPARE_A, 6'd1, '1, tsc_pkg::KIND_FUNCTION);
        send_item(OP_SPARE_B, 6'd1, '0, tsc_pkg::KIND_NORMAL);
        send_item(OP_SPARE_C, 6'd1, '1, tsc_pkg::KIND_AVERAGE);
        send_item(tsc_pkg::OP_CONFIG, 6'd1, '1, tsc_pkg::KIND_NORMAL);
        send_item(tsc_pkg::OP_READ, 6'd1, '0, tsc_pkg::KIND_NORMAL);
    endtask

    // random traffic, mostly on a few hot counters so updates land back to back
    task automatic test_random_traffic(input int n_items);
        logic [tsc_pkg::IDX_W-1:0] idx;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 60) idx = tsc_pkg::IDX_W'($urandom_range(0, 5));
            else idx = tsc_pkg::IDX_W'($urandom_range(0, NUM_CTRS - 1));
            send_item(pick_op(), idx, pick_operand(idx),
                      tsc_pkg::KIND_W'($urandom_range(0, 3)));
        end
    endtask

    // sink side: random backpressure, updated at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready = !(sink_stall_en && $urandom_range(0, 99) < STALL_PCT);
    end

    // compare every accepted result with the oldest owed snapshot
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (counter_snapshot_q.size() == 0) begin
                $display("%0t: unexpected result value=%h count=%h kind=%h", $time,
                         m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tuser);
                errors++;
            end else begin
                owed_snap = counter_snapshot_q.pop_front();
                if (m_axis_tdata[63:0] !== owed_snap.value) begin
                    $display("%0t: counter_value expected %h actual %h", $time,
                             owed_snap.value, m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== owed_snap.count) begin
                    $display("%0t: update_count expected %h actual %h", $time,
                             owed_snap.count, m_axis_tdata[95:64]);
                    errors++;
                end
                if (m_axis_tuser !== owed_snap.kind) begin
                    $display("%0t: counter_kind expected %h actual %h", $time,
                             owed_snap.kind, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results owed", $time,
                     HANG_LIMIT, counter_snapshot_q.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tsc_pkg::OP_READ;
        m_axis_tready = 1'b0;
        errors        = 0;
        idle_cycles   = 0;
        src_gap_en    = 1'b1;
        sink_stall_en = 1'b1;
        for (int c = 0; c < NUM_CTRS; c++) begin
            bank_values[c] = '0;
            bank_counts[c] = '0;
            bank_kinds[c]  = tsc_pkg::KIND_NORMAL;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_contents();
        test_normal_ops();
        test_maximum_kind();
        test_passive_kinds();
        test_spare_ops_and_clear();
        test_random_traffic(150);

        // let everything come back before resuming
        drain_results();

        // full-rate stretch, no gaps on either side
        src_gap_en    = 1'b0;
        sink_stall_en = 1'b0;
        test_random_traffic(100);
        src_gap_en    = 1'b1;
        sink_stall_en = 1'b1;
        test_random_traffic(150);

        drain_results();
        if (errors == 0 && counter_snapshot_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/tsc_pkg.sv
hdl/tsc_ram.sv
hdl/typed_statistics_counter_bank_top.sv
hdl/tsc_checker.sv
test/tb_top.sv
